// File: sv/flptm_pkg.sv
// Shared types and constants for the four-level page table mapper.
package flptm_pkg;

    localparam int POOL_PAGES = 64;
    localparam int ENTRIES_PER_TABLE = 512;
    localparam int IDX_W = $clog2(ENTRIES_PER_TABLE);
    localparam int PAGE_W = $clog2(POOL_PAGES);
    localparam int NFP_W = $clog2(POOL_PAGES + 1);
    localparam int ADDR_W = PAGE_W + IDX_W;
    localparam int FRAME_W = 40;
    localparam int VPAGE_W = 36;
    localparam int USABLE_W = 7;
    localparam int CFG_IDX_W = 2;

    localparam logic [CFG_IDX_W-1:0] CFG_TABLE_BASE = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_POOL_USABLE = 2'd1;

    typedef enum logic [1:0] {
        ST_DONE      = 2'd0,
        ST_EXHAUSTED = 2'd1,
        ST_ABSENT    = 2'd2
    } t_status;

    localparam logic OP_MAP = 1'b0;
    localparam logic OP_UNMAP = 1'b1;

    typedef struct packed {
        logic                operation;
        logic [VPAGE_W-1:0]  virtual_page;
        logic [FRAME_W-1:0]  physical_frame;
    } t_req;

    typedef struct packed {
        logic [1:0]          status;
        logic                leaf_was_present;
        logic [VPAGE_W-1:0]  invalidate_page;
        logic                invalidate_valid;
    } t_res;

    // Stored entry: present bit and frame number (flags other than present are constant).
    typedef struct packed {
        logic                present;
        logic [FRAME_W-1:0]  frame;
    } t_entry;

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_READ,
        S_CHECK,
        S_ZERO,
        S_LINK
    } t_state;

    typedef struct packed {
        logic    load;
        logic    rd;
        logic    sweep;
        logic    sweep_root;
        logic    link;
        logic    follow;
        logic    leaf;
        logic    done;
        t_status fin_status;
    } t_cmd;

    typedef struct packed {
        logic op;
        logic present;
        logic follow_ok;
        logic pool_ok;
        logic at_leaf;
        logic cnt_last;
    } t_stat;

endpackage

// File: sv/flptm_ctrl.sv
// Walk sequencer: root clear after reset, table reads, allocation and leaf update.
module flptm_ctrl (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             start,
    output logic             busy,
    input  flptm_pkg::t_stat i_stat,
    output flptm_pkg::t_cmd  o_cmd
);

    flptm_pkg::t_state r_state, n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= flptm_pkg::S_CLEAR;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        o_cmd = '0;
        o_cmd.fin_status = flptm_pkg::ST_DONE;
        busy = 1'b1;
        unique case (r_state)
            flptm_pkg::S_CLEAR: begin
                o_cmd.sweep = 1'b1;
                o_cmd.sweep_root = 1'b1;
                if (i_stat.cnt_last) begin
                    n_state = flptm_pkg::S_IDLE;
                end
            end
            flptm_pkg::S_IDLE: begin
                busy = 1'b0;
                if (start) begin
                    o_cmd.load = 1'b1;
                    n_state = flptm_pkg::S_READ;
                end
            end
            flptm_pkg::S_READ: begin
                o_cmd.rd = 1'b1;
                n_state = flptm_pkg::S_CHECK;
            end
            flptm_pkg::S_CHECK: begin
                if (i_stat.at_leaf) begin
                    o_cmd.leaf = 1'b1;
                    o_cmd.done = 1'b1;
                    n_state = flptm_pkg::S_IDLE;
                end else if (i_stat.present) begin
                    if (i_stat.follow_ok) begin
                        o_cmd.follow = 1'b1;
                        n_state = flptm_pkg::S_READ;
                    end else begin
                        o_cmd.done = 1'b1;
                        o_cmd.fin_status = (i_stat.op == flptm_pkg::OP_UNMAP) ?
                            flptm_pkg::ST_ABSENT : flptm_pkg::ST_EXHAUSTED;
                        n_state = flptm_pkg::S_IDLE;
                    end
                end else if (i_stat.op == flptm_pkg::OP_UNMAP) begin
                    o_cmd.done = 1'b1;
                    o_cmd.fin_status = flptm_pkg::ST_ABSENT;
                    n_state = flptm_pkg::S_IDLE;
                end else if (!i_stat.pool_ok) begin
                    o_cmd.done = 1'b1;
                    o_cmd.fin_status = flptm_pkg::ST_EXHAUSTED;
                    n_state = flptm_pkg::S_IDLE;
                end else begin
                    n_state = flptm_pkg::S_ZERO;
                end
            end
            flptm_pkg::S_ZERO: begin
                o_cmd.sweep = 1'b1;
                if (i_stat.cnt_last) begin
                    n_state = flptm_pkg::S_LINK;
                end
            end
            flptm_pkg::S_LINK: begin
                o_cmd.link = 1'b1;
                n_state = flptm_pkg::S_READ;
            end
            default: begin
                n_state = flptm_pkg::S_IDLE;
            end
        endcase
    end

endmodule

// File: sv/flptm_dp.sv
// Datapath: request and config registers, table store, allocator and result register.
module flptm_dp (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  flptm_pkg::t_req                     i_req,
    input  logic                                i_cfg_valid,
    input  logic [flptm_pkg::CFG_IDX_W-1:0]     i_cfg_index,
    input  logic [flptm_pkg::FRAME_W-1:0]       i_cfg_data,
    input  flptm_pkg::t_cmd                     i_cmd,
    output flptm_pkg::t_stat                    o_stat,
    output flptm_pkg::t_res                     o_res,
    output logic                                o_res_strobe
);

    flptm_pkg::t_entry r_mem [flptm_pkg::POOL_PAGES * flptm_pkg::ENTRIES_PER_TABLE];

    flptm_pkg::t_req                     r_req;
    logic [flptm_pkg::FRAME_W-1:0]       r_base;
    logic [flptm_pkg::USABLE_W-1:0]      r_usable;
    logic [flptm_pkg::NFP_W-1:0]         r_next_free;
    logic [flptm_pkg::PAGE_W-1:0]        r_page;
    logic [1:0]                          r_lvl;
    logic [flptm_pkg::IDX_W-1:0]         r_cnt;
    flptm_pkg::t_entry                   r_rd_data;
    flptm_pkg::t_res                     r_res;
    logic                                r_res_strobe;

    logic [flptm_pkg::IDX_W-1:0]         idx_cur;
    logic [flptm_pkg::ADDR_W-1:0]        addr_cur;
    logic [flptm_pkg::FRAME_W-1:0]       diff;
    logic [flptm_pkg::NFP_W-1:0]         limit;
    logic                                we;
    logic [flptm_pkg::ADDR_W-1:0]        waddr;
    flptm_pkg::t_entry                   wdata;
    logic [flptm_pkg::PAGE_W-1:0]        sweep_page;

    always_comb begin
        case (r_lvl)
            2'd0: idx_cur = r_req.virtual_page[4*flptm_pkg::IDX_W-1:3*flptm_pkg::IDX_W];
            2'd1: idx_cur = r_req.virtual_page[3*flptm_pkg::IDX_W-1:2*flptm_pkg::IDX_W];
            2'd2: idx_cur = r_req.virtual_page[2*flptm_pkg::IDX_W-1:flptm_pkg::IDX_W];
            default: idx_cur = r_req.virtual_page[flptm_pkg::IDX_W-1:0];
        endcase
    end

    assign addr_cur = {r_page, idx_cur};
    assign diff = r_rd_data.frame - r_base;

    always_comb begin
        if (r_usable > flptm_pkg::USABLE_W'(flptm_pkg::POOL_PAGES)) begin
            limit = flptm_pkg::NFP_W'(flptm_pkg::POOL_PAGES);
        end else begin
            limit = flptm_pkg::NFP_W'(r_usable);
        end
    end

    assign o_stat.op = r_req.operation;
    assign o_stat.present = r_rd_data.present;
    assign o_stat.follow_ok = diff < flptm_pkg::FRAME_W'(r_next_free);
    assign o_stat.pool_ok = r_next_free < limit;
    assign o_stat.at_leaf = (r_lvl == 2'd3);
    assign o_stat.cnt_last = &r_cnt;

    assign sweep_page = i_cmd.sweep_root ? '0 : r_next_free[flptm_pkg::PAGE_W-1:0];

    always_comb begin
        we = 1'b0;
        waddr = addr_cur;
        wdata = '0;
        if (i_cmd.sweep) begin
            we = 1'b1;
            waddr = {sweep_page, r_cnt};
        end else if (i_cmd.link) begin
            we = 1'b1;
            wdata.present = 1'b1;
            wdata.frame = r_base + flptm_pkg::FRAME_W'(r_next_free);
        end else if (i_cmd.leaf) begin
            we = 1'b1;
            if (r_req.operation == flptm_pkg::OP_MAP) begin
                wdata.present = 1'b1;
                wdata.frame = r_req.physical_frame;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (we) begin
            r_mem[waddr] <= wdata;
        end
        if (i_cmd.rd) begin
            r_rd_data <= r_mem[addr_cur];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_base <= '0;
            r_usable <= flptm_pkg::USABLE_W'(64);
            r_next_free <= flptm_pkg::NFP_W'(1);
            r_cnt <= '0;
            r_lvl <= '0;
            r_page <= '0;
            r_res_strobe <= 1'b0;
        end else begin
            r_res_strobe <= i_cmd.done;
            if (i_cfg_valid) begin
                if (i_cfg_index == flptm_pkg::CFG_TABLE_BASE) begin
                    r_base <= i_cfg_data;
                end else if (i_cfg_index == flptm_pkg::CFG_POOL_USABLE) begin
                    r_usable <= i_cfg_data[flptm_pkg::USABLE_W-1:0];
                end
            end
            if (i_cmd.sweep) begin
                r_cnt <= r_cnt + 1'b1;
            end
            if (i_cmd.load) begin
                r_lvl <= '0;
                r_page <= '0;
            end else if (i_cmd.follow) begin
                r_lvl <= r_lvl + 1'b1;
                r_page <= diff[flptm_pkg::PAGE_W-1:0];
            end else if (i_cmd.link) begin
                r_lvl <= r_lvl + 1'b1;
                r_page <= r_next_free[flptm_pkg::PAGE_W-1:0];
                r_next_free <= r_next_free + 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_req <= i_req;
        end
        if (i_cmd.done) begin
            r_res.status <= i_cmd.fin_status;
            r_res.leaf_was_present <= i_cmd.leaf & r_rd_data.present;
            r_res.invalidate_page <= r_req.virtual_page;
            r_res.invalidate_valid <= 1'b1;
        end
    end

    assign o_res = r_res;
    assign o_res_strobe = r_res_strobe;

endmodule

// File: sv/four_level_page_table_mapper_core.sv
// Top level of the four-level page table mapper.
// After reset the block clears all 512 entries of the root table, one entry a cycle,
// with busy high. A request is taken when start is high and busy is low and gives one
// result beat on o_res, marked by o_res_strobe for a single cycle; the receiver
// cannot stall it. Each table level is a registered read of the table store, then
// the check; each newly allocated table adds 512 zeroing writes through the store's
// single write port plus the link write. Configuration writes are always accepted
// and take effect at once; write them only while idle.
module four_level_page_table_mapper_core (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                start,
    output logic                                busy,
    input  flptm_pkg::t_req                     i_req,
    output flptm_pkg::t_res                     o_res,
    output logic                                o_res_strobe,
    input  logic                                i_cfg_valid,
    output logic                                o_cfg_ready,
    input  logic [flptm_pkg::CFG_IDX_W-1:0]     i_cfg_index,
    input  logic [flptm_pkg::FRAME_W-1:0]       i_cfg_data
);

    flptm_pkg::t_cmd  cmd;
    flptm_pkg::t_stat stat;

    assign o_cfg_ready = 1'b1;

    flptm_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .start   (start),
        .busy    (busy),
        .i_stat  (stat),
        .o_cmd   (cmd)
    );

    flptm_dp u_dp (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_req        (i_req),
        .i_cfg_valid  (i_cfg_valid),
        .i_cfg_index  (i_cfg_index),
        .i_cfg_data   (i_cfg_data),
        .i_cmd        (cmd),
        .o_stat       (stat),
        .o_res        (o_res),
        .o_res_strobe (o_res_strobe)
    );

endmodule
